[rtl/indexed_shift_array_assert.svh]
// Assertion macros used by the indexed_shift_array module.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef INDEXED_SHIFT_ARRAY_ASSERT_SVH
`define INDEXED_SHIFT_ARRAY_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ISA_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ISA_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/isa_pkg.sv]
// Shared types and constants for the indexed shift array.
// Used by isa_cell and indexed_shift_array; depends on nothing.
package isa_pkg;

  localparam int unsigned Depth       = 16;
  localparam int unsigned ElemBits    = 32;
  localparam int unsigned CntW        = $clog2(Depth + 1);
  localparam int unsigned IndexW      = 5;
  localparam int unsigned CmpW        = (CntW > IndexW) ? CntW : IndexW;
  localparam int unsigned ValueW      = 32;

  typedef logic [ElemBits-1:0] elem_t;
  typedef logic [CntW-1:0]     cnt_t;
  typedef logic [CmpW-1:0]     cmp_t;

  typedef enum logic [2:0] {
    KIND_PUSH   = 3'd0,
    KIND_POP    = 3'd1,
    KIND_INSERT = 3'd2,
    KIND_REMOVE = 3'd3,
    KIND_READ   = 3'd4,
    KIND_WRITE  = 3'd5,
    KIND_CLEAR  = 3'd6
  } kind_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_EMPTY = 2'd3
  } status_e;

  typedef enum logic [1:0] {
    CELL_HOLD  = 2'd0,
    CELL_LOAD  = 2'd1,
    CELL_LEFT  = 2'd2,
    CELL_RIGHT = 2'd3
  } cell_op_e;

  typedef struct packed {
    cell_op_e op;
    logic     sel;
  } cell_ctrl_t;

endpackage

[rtl/isa_cell.sv]
// One storage cell of the indexed shift array: holds one element word.
// Depends on isa_pkg for the element type and the cell control struct.
module isa_cell (
  input  logic               clk_i,
  input  isa_pkg::cell_ctrl_t ctrl_i,
  input  isa_pkg::elem_t     load_i,
  input  isa_pkg::elem_t     left_i,
  input  isa_pkg::elem_t     right_i,
  output isa_pkg::elem_t     word_o,
  output isa_pkg::elem_t     rd_o
);

  isa_pkg::elem_t word_q;
  isa_pkg::elem_t word_d;

  always_comb begin
    unique case (ctrl_i.op)
      isa_pkg::CELL_HOLD:  word_d = word_q;
      isa_pkg::CELL_LOAD:  word_d = load_i;
      isa_pkg::CELL_LEFT:  word_d = left_i;
      isa_pkg::CELL_RIGHT: word_d = right_i;
      default:             word_d = word_q;
    endcase
  end

  always_ff @(posedge clk_i) begin
    word_q <= word_d;
  end

  assign word_o = word_q;
  assign rd_o   = ctrl_i.sel ? word_q : '0;

endmodule

[rtl/indexed_shift_array.sv]
// Indexed shift array: an ordered row of cells with push, pop, insert, remove, read,
// write and clear. Each item's result appears with done_o in the cycle after
// acceptance, and a new item may be accepted every cycle (busy_o stays low).
// Insert and remove shift the cells from the index upward in parallel, so depth does not slow them.
// Reset clears the element count and the result strobe; cell contents are not reset.
module indexed_shift_array (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  output logic        busy_o,
  input  logic [2:0]  kind_i,
  input  logic [4:0]  index_i,
  input  logic [31:0] value_i,
  output logic        done_o,
  output logic [1:0]  status_o,
  output logic [31:0] read_value_o,
  output logic [4:0]  count_o
);

  `include "indexed_shift_array_assert.svh"

  localparam int unsigned Depth = isa_pkg::Depth;

  logic                fire;
  isa_pkg::cnt_t       fill_q;
  isa_pkg::cnt_t       fill_d;
  isa_pkg::cmp_t       idx;
  isa_pkg::cmp_t       fill_w;
  isa_pkg::elem_t      load_word;
  isa_pkg::status_e    status_d;
  isa_pkg::status_e    status_q;
  logic                done_q;
  isa_pkg::elem_t      rdata_d;
  logic [31:0]         rdata_q;
  logic                full;
  logic                empty;
  logic                do_load;
  logic                do_left;
  logic                do_right;
  logic                do_read;
  isa_pkg::cmp_t       target;

  isa_pkg::cell_ctrl_t ctrl  [Depth];
  isa_pkg::elem_t      words [Depth];
  isa_pkg::elem_t      rds   [Depth];

  assign busy_o    = 1'b0;
  assign fire      = start_i && !busy_o;
  assign idx       = isa_pkg::CmpW'(index_i);
  assign fill_w    = isa_pkg::CmpW'(fill_q);
  assign load_word = isa_pkg::ElemBits'(value_i);
  assign full      = (fill_w == isa_pkg::CmpW'(Depth));
  assign empty     = (fill_q == '0);

  always_comb begin
    status_d = isa_pkg::ST_OK;
    fill_d   = fill_q;
    do_load  = 1'b0;
    do_left  = 1'b0;
    do_right = 1'b0;
    do_read  = 1'b0;
    target   = idx;
    if (fire) begin
      unique case (kind_i)
        isa_pkg::KIND_PUSH: begin
          target = fill_w;
          if (full) begin
            status_d = isa_pkg::ST_FULL;
          end else begin
            do_load = 1'b1;
            fill_d  = fill_q + isa_pkg::CntW'(1);
          end
        end
        isa_pkg::KIND_POP: begin
          if (empty) begin
            status_d = isa_pkg::ST_EMPTY;
          end else begin
            fill_d = fill_q - isa_pkg::CntW'(1);
          end
        end
        isa_pkg::KIND_INSERT: begin
          if (idx > fill_w) begin
            status_d = isa_pkg::ST_RANGE;
          end else if (full) begin
            status_d = isa_pkg::ST_FULL;
          end else begin
            do_load = 1'b1;
            do_left = 1'b1;
            fill_d  = fill_q + isa_pkg::CntW'(1);
          end
        end
        isa_pkg::KIND_REMOVE: begin
          if (idx >= fill_w) begin
            status_d = isa_pkg::ST_RANGE;
          end else begin
            do_right = 1'b1;
            fill_d   = fill_q - isa_pkg::CntW'(1);
          end
        end
        isa_pkg::KIND_READ: begin
          if (idx >= fill_w) begin
            status_d = isa_pkg::ST_RANGE;
          end else begin
            do_read = 1'b1;
          end
        end
        isa_pkg::KIND_WRITE: begin
          if (idx >= fill_w) begin
            status_d = isa_pkg::ST_RANGE;
          end else begin
            do_load = 1'b1;
          end
        end
        isa_pkg::KIND_CLEAR: begin
          fill_d = '0;
        end
        default: begin
          status_d = isa_pkg::ST_OK;
        end
      endcase
    end
  end

  for (genvar i = 0; i < Depth; i++) begin : g_cell
    localparam isa_pkg::cmp_t Pos = isa_pkg::CmpW'(i);
    isa_pkg::elem_t left_w;
    isa_pkg::elem_t right_w;

    always_comb begin
      ctrl[i].sel = do_read && (target == Pos);
      priority if (do_load && (target == Pos)) begin
        ctrl[i].op = isa_pkg::CELL_LOAD;
      end else if (do_left && (Pos > target)) begin
        ctrl[i].op = isa_pkg::CELL_LEFT;
      end else if (do_right && (Pos >= target)) begin
        ctrl[i].op = isa_pkg::CELL_RIGHT;
      end else begin
        ctrl[i].op = isa_pkg::CELL_HOLD;
      end
    end

    if (i == 0) begin : g_first
      assign left_w = words[i];
    end else begin : g_mid
      assign left_w = words[i-1];
    end
    if (i == Depth - 1) begin : g_last
      assign right_w = words[i];
    end else begin : g_inner
      assign right_w = words[i+1];
    end

    isa_cell u_cell (
      .clk_i   (clk_i),
      .ctrl_i  (ctrl[i]),
      .load_i  (load_word),
      .left_i  (left_w),
      .right_i (right_w),
      .word_o  (words[i]),
      .rd_o    (rds[i])
    );
  end

  always_comb begin
    rdata_d = '0;
    for (int unsigned k = 0; k < Depth; k++) begin
      rdata_d = rdata_d | rds[k];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fill_q <= '0;
      done_q <= 1'b0;
    end else begin
      fill_q <= fill_d;
      done_q <= fire;
    end
  end

  always_ff @(posedge clk_i) begin
    status_q <= status_d;
    rdata_q  <= 32'(rdata_d);
  end

  assign done_o       = done_q;
  assign status_o     = status_q;
  assign read_value_o = rdata_q;
  assign count_o      = 5'(fill_q);

  `ISA_ASSERT_NEXT(a_done_follows, fire, done_o, "Accepted item produced no result.")
  `ISA_ASSERT_NOW(a_count_bound, 1'b1, fill_w <= isa_pkg::CmpW'(Depth),
    "Element count exceeds capacity.")
  `ISA_ASSERT_NOW(a_rd_zero, done_o && (status_q != isa_pkg::ST_OK), read_value_o == '0,
    "Read value not zero on a failed item.")
  `ISA_ASSERT_NEXT(a_push_grows, fire && (kind_i == isa_pkg::KIND_PUSH) && !full,
    fill_q == ($past(fill_q) + isa_pkg::CntW'(1)), "Successful push did not add an element.")
  `ISA_ASSERT_NEXT(a_clear_empties, fire && (kind_i == isa_pkg::KIND_CLEAR),
    (count_o == '0) && (status_q == isa_pkg::ST_OK), "Clear did not empty the array.")

endmodule

[sim/tb_top.sv]
// Self-checking testbench for indexed_shift_array: directed and random array operations
// are driven through the start/busy command port, and every done_o result is checked.
// Depends on isa_pkg and the indexed_shift_array RTL only.
module tb_top;
  import isa_pkg::*;

  localparam logic [2:0] KindUnused = 3'd7;
  localparam int unsigned RandomItems = 550;

  typedef struct {
    logic [2:0]  kind;
    logic [4:0]  index;
    logic [31:0] value;
    int unsigned gap_pct;
  } op_item_t;

  typedef struct {
    status_e     status;
    logic [31:0] read_value;
    logic [4:0]  count;
  } op_result_t;

  typedef struct {
    elem_t store [Depth];
    cnt_t  fill;
  } array_state_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start_i = 1'b0;
  logic [2:0]  kind_i = '0;
  logic [4:0]  index_i = '0;
  logic [31:0] value_i = '0;
  logic        busy_o;
  logic        done_o;
  logic [1:0]  status_o;
  logic [31:0] read_value_o;
  logic [4:0]  count_o;

  op_item_t     pending_items[$];
  op_result_t   expected_results[$];
  array_state_t array_model;
  array_state_t plan_state;
  int unsigned  total_items = 0;
  int unsigned  accepted_items = 0;
  int unsigned  errors = 0;

  indexed_shift_array dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .kind_i       (kind_i),
    .index_i      (index_i),
    .value_i      (value_i),
    .done_o       (done_o),
    .status_o     (status_o),
    .read_value_o (read_value_o),
    .count_o      (count_o)
  );

  function automatic void apply_op(inout array_state_t s, input op_item_t it,
                                   output op_result_t r);
    int f;
    int ix;
    f = int'(s.fill);
    ix = int'(it.index);
    r.status = ST_OK;
    r.read_value = '0;
    case (it.kind)
      KIND_PUSH: begin
        if (f >= Depth) begin
          r.status = ST_FULL;
        end else begin
          s.store[f] = elem_t'(it.value);
          f++;
        end
      end
      KIND_POP: begin
        if (f == 0) r.status = ST_EMPTY;
        else f--;
      end
      KIND_INSERT: begin
        if (ix > f) begin
          r.status = ST_RANGE;
        end else if (f >= Depth) begin
          r.status = ST_FULL;
        end else begin
          for (int i = Depth - 1; i > 0; i--) begin
            if (i <= f && i > ix) s.store[i] = s.store[i-1];
          end
          s.store[ix] = elem_t'(it.value);
          f++;
        end
      end
      KIND_REMOVE: begin
        if (ix >= f) begin
          r.status = ST_RANGE;
        end else begin
          for (int i = 0; i < Depth - 1; i++) begin
            if (i >= ix && i + 1 < f) s.store[i] = s.store[i+1];
          end
          f--;
        end
      end
      KIND_READ: begin
        if (ix >= f) r.status = ST_RANGE;
        else r.read_value = 32'(s.store[ix]);
      end
      KIND_WRITE: begin
        if (ix >= f) r.status = ST_RANGE;
        else s.store[ix] = elem_t'(it.value);
      end
      KIND_CLEAR: f = 0;
      default: ;
    endcase
    s.fill = cnt_t'(f);
    r.count = 5'(s.fill);
  endfunction

  function automatic void add_item(logic [2:0] kind, logic [4:0] index, logic [31:0] value,
                                   int unsigned gap_pct);
    op_item_t   it;
    op_result_t unused_res;
    it.kind = kind;
    it.index = index;
    it.value = value;
    it.gap_pct = gap_pct;
    apply_op(plan_state, it, unused_res);
    pending_items.push_back(it);
  endfunction

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
  end

  initial begin
    #2000000;
    $display("** indexed_shift_array: FAILED **");
    $finish;
  end

  always @(posedge clk_i or negedge rst_ni) begin : driver
    op_item_t   cur;
    op_item_t   nxt;
    op_result_t res;
    if (!rst_ni) begin
      start_i <= 1'b0;
      kind_i <= '0;
      index_i <= '0;
      value_i <= '0;
    end else begin
      if (start_i && !busy_o) begin
        cur.kind = kind_i;
        cur.index = index_i;
        cur.value = value_i;
        cur.gap_pct = 0;
        apply_op(array_model, cur, res);
        expected_results.push_back(res);
        accepted_items++;
      end
      if (start_i && busy_o) begin
      end else if (pending_items.size() != 0 &&
                   $urandom_range(0, 99) >= pending_items[0].gap_pct) begin
        nxt = pending_items.pop_front();
        start_i <= 1'b1;
        kind_i <= nxt.kind;
        index_i <= nxt.index;
        value_i <= nxt.value;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin : monitor
    op_result_t want;
    if (rst_ni && done_o) begin
      if (expected_results.size() == 0) begin
        errors++;
        $display("%0t: unexpected result: status %0d read_value %h count %0d",
                 $time, status_o, read_value_o, count_o);
      end else begin
        want = expected_results.pop_front();
        if (status_o !== want.status) begin
          errors++;
          $display("%0t: status mismatch: expected %0d, actual %0d",
                   $time, want.status, status_o);
        end
        if (read_value_o !== want.read_value) begin
          errors++;
          $display("%0t: read_value mismatch: expected %h, actual %h",
                   $time, want.read_value, read_value_o);
        end
        if (count_o !== want.count) begin
          errors++;
          $display("%0t: count mismatch: expected %0d, actual %0d",
                   $time, want.count, count_o);
        end
      end
    end
  end

  initial begin : stimulus
    int unsigned phase_gap [3];
    int unsigned mode;
    int unsigned r;
    int          f;
    logic [2:0]  k;
    logic [4:0]  idx;
    logic [31:0] v;
    int          guard;

    phase_gap[0] = 0;
    phase_gap[1] = 74;
    phase_gap[2] = 6;
    for (int i = 0; i < Depth; i++) begin
      array_model.store[i] = '0;
      plan_state.store[i] = '0;
    end
    array_model.fill = '0;
    plan_state.fill = '0;

    // Empty array corner cases, front/middle/end inserts, reads, writes, removes, clear.
    add_item(KIND_POP, 5'd0, 32'h0, 0);
    add_item(KIND_READ, 5'd0, 32'h0, 0);
    add_item(KIND_REMOVE, 5'd0, 32'h0, 0);
    add_item(KIND_WRITE, 5'd0, 32'h1234_5678, 0);
    add_item(KIND_INSERT, 5'd1, 32'hDEAD_BEEF, 0);
    add_item(KIND_INSERT, 5'd0, 32'h0, 0);
    add_item(KIND_PUSH, 5'd31, 32'hFFFF_FFFF, 0);
    add_item(KIND_INSERT, 5'd1, 32'h5A5A_A5A5, 0);
    add_item(KIND_INSERT, 5'd3, 32'h0000_0001, 0);
    add_item(KIND_READ, 5'd0, 32'hFFFF_FFFF, 0);
    add_item(KIND_READ, 5'd1, 32'h0, 0);
    add_item(KIND_READ, 5'd2, 32'h0, 0);
    add_item(KIND_READ, 5'd3, 32'h0, 0);
    add_item(KIND_WRITE, 5'd2, 32'h8000_0000, 0);
    add_item(KIND_READ, 5'd2, 32'h0, 0);
    add_item(KIND_REMOVE, 5'd1, 32'h0, 0);
    add_item(KIND_READ, 5'd31, 32'h0, 0);
    add_item(KIND_REMOVE, 5'd3, 32'h0, 0);
    add_item(KIND_INSERT, 5'd31, 32'hCAFE_F00D, 0);
    add_item(KindUnused, 5'd16, 32'hFFFF_FFFF, 0);
    add_item(KIND_CLEAR, 5'd0, 32'h0, 0);
    add_item(KIND_READ, 5'd0, 32'h0, 0);
    add_item(KIND_POP, 5'd0, 32'h0, 0);

    // Every 25 items a segment picks at random between growing, shrinking and mixed traffic.
    mode = 0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 25 == 0) mode = $urandom_range(0, 2);
      r = $urandom_range(0, 99);
      if (r < 4) begin
        k = (r < 2) ? 3'(KIND_CLEAR) : KindUnused;
      end else if (mode == 0) begin
        k = (r < 50) ? 3'(KIND_PUSH) : (r < 75) ? 3'(KIND_INSERT) :
            (r < 85) ? 3'(KIND_READ) : (r < 93) ? 3'(KIND_WRITE) :
            (r < 97) ? 3'(KIND_REMOVE) : 3'(KIND_POP);
      end else if (mode == 1) begin
        k = (r < 35) ? 3'(KIND_POP) : (r < 65) ? 3'(KIND_REMOVE) :
            (r < 80) ? 3'(KIND_READ) : (r < 90) ? 3'(KIND_WRITE) :
            (r < 95) ? 3'(KIND_PUSH) : 3'(KIND_INSERT);
      end else begin
        k = 3'($urandom_range(0, 5));
      end
      f = int'(plan_state.fill);
      if ($urandom_range(0, 99) < 15 || (f == 0 && k != KIND_INSERT)) begin
        idx = 5'($urandom_range(0, 31));
      end else if (k == KIND_INSERT) begin
        idx = 5'($urandom_range(0, f));
      end else begin
        idx = 5'($urandom_range(0, f - 1));
      end
      r = $urandom_range(0, 15);
      v = (r == 0) ? 32'h0 : (r == 1) ? 32'hFFFF_FFFF : $urandom;
      add_item(k, idx, v, phase_gap[(n / 50) % 3]);
    end
    total_items = pending_items.size();

    wait (accepted_items == total_items);
    guard = 0;
    while (expected_results.size() != 0 && guard < 100) begin
      @(posedge clk_i);
      guard++;
    end
    repeat (4) @(posedge clk_i);
    if (expected_results.size() != 0) begin
      errors++;
      $display("%0t: %0d expected results never arrived", $time, expected_results.size());
    end
    if (errors == 0) begin
      $display("** indexed_shift_array: PASSED **");
    end else begin
      $display("** indexed_shift_array: FAILED **");
    end
    $finish;
  end

endmodule

[sim.f]
+incdir+rtl
rtl/isa_pkg.sv
rtl/isa_cell.sv
rtl/indexed_shift_array.sv
sim/tb_top.sv
